// ===== sv/ulpd_pkg.sv =====
// ulpd_pkg: shared types, character constants and lookup functions
// for the uri-list path decoder; no dependencies
package ulpd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned MAX_RES     = 4;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [3:0] SCHEME_LEN = 4'd7;
  localparam logic [3:0] HOST_LEN   = 4'd9;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_DROP = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } res_t;

  // results caused by one text byte
  typedef struct packed {
    logic [2:0] cnt;
    res_t [3:0] ent;
  } grp_t;

  // "file://"
  function automatic logic [7:0] scheme_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h66;
      3'd1: c = 8'h69;
      3'd2: c = 8'h6C;
      3'd3: c = 8'h65;
      3'd4: c = 8'h3A;
      3'd5: c = 8'h2F;
      3'd6: c = 8'h2F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "localhost"
  function automatic logic [7:0] host_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0: c = 8'h6C;
      4'd1: c = 8'h6F;
      4'd2: c = 8'h63;
      4'd3: c = 8'h61;
      4'd4: c = 8'h6C;
      4'd5: c = 8'h68;
      4'd6: c = 8'h6F;
      4'd7: c = 8'h73;
      4'd8: c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // {is hex digit, nibble value}
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== sv/ulpd_if.sv =====
// ulpd_in_if / ulpd_out_if: valid/ready channels of the path decoder
// depends on nothing
interface ulpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface ulpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       run_last;

  modport source (output valid, output out_byte, output kind, output run_last, input ready);
  modport sink   (input valid, input out_byte, input kind, input run_last, output ready);
endinterface

// ===== sv/ulpd_front.sv =====
// ulpd_front: line parser, takes one text byte a cycle while the queue has room and builds its result group
// depends on ulpd_pkg and ulpd_if
module ulpd_front (
  input  logic          clk,
  input  logic          rst_n,
  ulpd_in_if.sink       in_ch,
  input  logic          q_full,
  output logic          push,
  output ulpd_pkg::grp_t push_grp
);
  import ulpd_pkg::*;

  typedef enum logic [3:0] {
    PH_SCHEME = 4'b0001,
    PH_AUTH   = 4'b0010,
    PH_PATH   = 4'b0100,
    PH_SKIP   = 4'b1000
  } phase_t;

  typedef enum logic [3:0] {
    HOLD_NONE   = 4'b0001,
    HOLD_CR     = 4'b0010,
    HOLD_PCT    = 4'b0100,
    HOLD_PCTHEX = 4'b1000
  } hold_t;

  phase_t     phase_r, phase_nxt;
  hold_t      hold_r, hold_nxt;
  logic [3:0] match_r, match_nxt;
  logic [7:0] hexb_r, hexb_nxt;
  grp_t       grp;
  logic       accept;

  function automatic grp_t add(input grp_t g, input logic [7:0] d, input kind_t k);
    grp_t r;
    r = g;
    if (g.cnt < 3'(MAX_RES)) begin
      r.ent[g.cnt[1:0]] = '{data: d, kind: k};
      r.cnt = g.cnt + 3'd1;
    end
    return r;
  endfunction

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    logic [7:0] b;
    logic [4:0] lo;
    logic [4:0] hi;
    logic [7:0] v;
    logic       done;
    b         = in_ch.in_byte;
    lo        = hex_val(b);
    hi        = hex_val(hexb_r);
    v         = {hi[3:0], lo[3:0]};
    done      = 1'b0;
    phase_nxt = phase_r;
    hold_nxt  = hold_r;
    match_nxt = match_r;
    hexb_nxt  = hexb_r;
    grp       = '0;

    if (b == CH_LF) begin
      if (phase_r == PH_PATH) begin
        case (hold_r)
          HOLD_PCTHEX: begin
            grp = add(grp, CH_PCT, KIND_BYTE);
            grp = add(grp, hexb_r, KIND_BYTE);
          end
          HOLD_PCT: grp = add(grp, CH_PCT, KIND_BYTE);
          default: ;
        endcase
        grp = add(grp, 8'h00, KIND_END);
      end
      phase_nxt = PH_SCHEME;
      match_nxt = '0;
      hold_nxt  = HOLD_NONE;
    end else begin
      case (phase_r)
        PH_SCHEME: begin
          if (match_r < SCHEME_LEN && b == scheme_char(match_r[2:0])) begin
            match_nxt = match_r + 4'd1;
            if (match_nxt == SCHEME_LEN) begin
              phase_nxt = PH_AUTH;
              match_nxt = '0;
            end
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_AUTH: begin
          if (b == CH_SLASH) begin
            if (match_r == 4'd0 || match_r == HOST_LEN) begin
              phase_nxt = PH_PATH;
              hold_nxt  = HOLD_NONE;
              grp       = add(grp, b, KIND_BYTE);
            end else begin
              phase_nxt = PH_SKIP;
            end
          end else if (match_r < HOST_LEN && b == host_char(match_r)) begin
            match_nxt = match_r + 4'd1;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_PATH: begin
          case (hold_r)
            HOLD_PCTHEX: begin
              hold_nxt = HOLD_NONE;
              if (lo[4] && hi[4]) begin
                done = 1'b1;
                if (v == 8'h00) begin
                  phase_nxt = PH_SKIP;
                  grp       = add(grp, 8'h00, KIND_DROP);
                end else begin
                  grp = add(grp, v, KIND_BYTE);
                end
              end else begin
                grp = add(grp, CH_PCT, KIND_BYTE);
                grp = add(grp, hexb_r, KIND_BYTE);
              end
            end
            HOLD_PCT: begin
              if (lo[4]) begin
                hexb_nxt = b;
                hold_nxt = HOLD_PCTHEX;
                done     = 1'b1;
              end else begin
                grp      = add(grp, CH_PCT, KIND_BYTE);
                hold_nxt = HOLD_NONE;
              end
            end
            HOLD_CR: begin
              grp      = add(grp, CH_CR, KIND_BYTE);
              hold_nxt = HOLD_NONE;
            end
            default: ;
          endcase
          if (!done) begin
            if (b == CH_PCT) begin
              hold_nxt = HOLD_PCT;
            end else if (b == CH_CR) begin
              hold_nxt = HOLD_CR;
            end else begin
              grp = add(grp, b, KIND_BYTE);
            end
          end
        end
        default: ;
      endcase

      // text end closes the line as a line feed would
      if (in_ch.end_of_text) begin
        if (phase_nxt == PH_PATH) begin
          case (hold_nxt)
            HOLD_PCTHEX: begin
              grp = add(grp, CH_PCT, KIND_BYTE);
              grp = add(grp, hexb_nxt, KIND_BYTE);
            end
            HOLD_PCT: grp = add(grp, CH_PCT, KIND_BYTE);
            default: ;
          endcase
          grp = add(grp, 8'h00, KIND_END);
        end
        phase_nxt = PH_SCHEME;
        match_nxt = '0;
        hold_nxt  = HOLD_NONE;
      end
    end
  end

  assign push     = accept && (grp.cnt != 3'd0);
  assign push_grp = grp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SCHEME;
      hold_r  <= HOLD_NONE;
      match_r <= '0;
      hexb_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hold_r  <= hold_nxt;
      match_r <= match_nxt;
      hexb_r  <= hexb_nxt;
    end
  end

endmodule

// ===== sv/ulpd_fifo.sv =====
// ulpd_fifo: short register queue of result groups between parser and output side
// depends on ulpd_pkg
module ulpd_fifo #(
  parameter int unsigned Depth = ulpd_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ulpd_pkg::grp_t push_grp,
  input  logic           pop,
  output ulpd_pkg::grp_t head,
  output logic           full,
  output logic           empty
);
  import ulpd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  grp_t            mem_r [Depth];
  logic [PtrW-1:0] wr_r, wr_nxt;
  logic [PtrW-1:0] rd_r, rd_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CntW'(Depth));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PtrW'(Depth - 1)) ? '0 : wr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PtrW'(Depth - 1)) ? '0 : rd_r + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CntW'(1);
      2'b01:   cnt_nxt = cnt_r - CntW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_grp;
    end
  end

endmodule

// ===== sv/ulpd_back.sv =====
// ulpd_back: walks the head group one result a cycle into the output
// register while it is empty or taken; depends on ulpd_pkg and ulpd_if
module ulpd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  ulpd_pkg::grp_t head,
  input  logic           empty,
  output logic           pop,
  ulpd_out_if.source     out_ch
);
  import ulpd_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r;
  res_t       res_r;
  logic       last_r;
  logic       load;
  logic       is_last;

  assign load    = (!vld_r || out_ch.ready) && !empty;
  assign is_last = ({1'b0, idx_r} == head.cnt - 3'd1);
  assign pop     = load && is_last;
  assign idx_nxt = is_last ? '0 : idx_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        vld_r <= 1'b1;
        idx_r <= idx_nxt;
      end else if (out_ch.ready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= head.ent[idx_r];
      last_r <= is_last;
    end
  end

  assign out_ch.valid    = vld_r;
  assign out_ch.out_byte = res_r.data;
  assign out_ch.kind     = res_r.kind;
  assign out_ch.run_last = last_r;

endmodule

// ===== sv/uri_list_path_decoder_core.sv =====
// uri_list_path_decoder_core: file url path extraction with percent decoding
// path: the result group of a byte is written into the group queue, then loaded into the output register
// throughput: one text byte a cycle while the queue has room; results leave one a cycle while the output
// is ready, the group queue absorbing bursts of bytes that cause several results
// reset: synchronous active-low rst_n clears parser phase, queue pointers and output valid
module uri_list_path_decoder_core #(
  parameter int unsigned QueueDepth = ulpd_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  ulpd_in_if.sink    in_ch,
  ulpd_out_if.source out_ch
);
  import ulpd_pkg::*;

  // parser to queue
  logic push;
  grp_t push_grp;
  logic q_full;

  // queue to output side
  grp_t head;
  logic q_empty;
  logic pop;

  // front: scheme and authority matching, percent decoding, result grouping
  ulpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_grp (push_grp)
  );

  // decoupling queue, one entry per byte that causes any result
  ulpd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: serialises groups into beats, marks the last of each group
  ulpd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== tb/uri_list_path_decoder_core_tb.sv =====
// uri_list_path_decoder_core_tb: self-checking bench for the uri-list path decoder
// checks every result beat against a cycle-free model of file url path extraction
// depends on ulpd_pkg, ulpd_in_if / ulpd_out_if and uri_list_path_decoder_core
module uri_list_path_decoder_core_tb;
  import ulpd_pkg::*;

  localparam int    RANDOM_BYTES   = 190;
  localparam int    WATCHDOG_LIMIT = 4000;
  localparam int    DRAIN_CYCLES   = 20;
  localparam int    MAX_PRINTED    = 50;
  localparam string SCHEME_TXT     = "file://";
  localparam string HOST_TXT       = "localhost";
  localparam string NON_HEX_TXT    = "gzGZ/._~";

  typedef enum logic [1:0] {
    PH_SCHEME,
    PH_AUTH,
    PH_PATH,
    PH_SKIP
  } phase_t;

  typedef struct {
    logic [7:0] b;
    logic       eot;
  } text_beat_t;

  typedef struct {
    logic [7:0] data;
    kind_t      kind;
    logic       run_last;
  } path_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  ulpd_in_if  in_ch ();
  ulpd_out_if out_ch ();

  uri_list_path_decoder_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // text bytes still to send, and path beats still owed by the block
  text_beat_t text_bytes [$];
  path_beat_t path_beats_due [$];
  int         n_total;
  int         n_in_beats;
  int         n_out_beats;
  int         n_errors;
  int         idle_cycles;

  // ---------------------------------------------------------------------------
  // line decoder model: same state as the block, advanced once per accepted beat
  // ---------------------------------------------------------------------------
  phase_t     line_phase;
  logic [3:0] match_idx;
  logic [7:0] held [3];
  logic [1:0] held_n;
  path_beat_t step_beats [$];

  function automatic int nibble_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  // one text byte never causes more than MAX_RES beats
  function automatic void emit_beat(logic [7:0] d, kind_t k);
    path_beat_t pb;
    pb = '{d, k, 1'b0};
    if (step_beats.size() < MAX_RES) step_beats.insert(step_beats.size(), pb);
  endfunction

  function automatic void restart_line();
    line_phase = PH_SCHEME;
    match_idx  = 4'd0;
    held_n     = 2'd0;
  endfunction

  // line end inside a path: held percent and digit go out literally, a held cr is dropped
  function automatic void flush_and_close();
    if (held_n == 2'd2) begin
      emit_beat(CH_PCT, KIND_BYTE);
      emit_beat(held[1], KIND_BYTE);
    end else if (held_n == 2'd1 && held[0] == CH_PCT) begin
      emit_beat(CH_PCT, KIND_BYTE);
    end
    held_n = 2'd0;
    emit_beat(8'h00, KIND_END);
  endfunction

  function automatic void take_path_byte(logic [7:0] b);
    int         lo;
    int         hi;
    logic [7:0] v;
    if (held_n == 2'd2) begin
      lo = nibble_of(b);
      hi = nibble_of(held[1]);
      if (lo >= 0 && hi >= 0) begin
        v      = 8'(hi * 16 + lo);
        held_n = 2'd0;
        if (v == 8'h00) begin
          // decoded nul: reject the path, ignore the rest of the line
          line_phase = PH_SKIP;
          emit_beat(8'h00, KIND_DROP);
        end else begin
          emit_beat(v, KIND_BYTE);
        end
        return;
      end
      emit_beat(CH_PCT, KIND_BYTE);
      emit_beat(held[1], KIND_BYTE);
      held_n = 2'd0;
    end else if (held_n == 2'd1 && held[0] == CH_PCT) begin
      if (nibble_of(b) >= 0) begin
        held[1] = b;
        held_n  = 2'd2;
        return;
      end
      // stray percent: literal, and this byte is scanned afresh
      emit_beat(CH_PCT, KIND_BYTE);
      held_n = 2'd0;
    end else if (held_n != 2'd0) begin
      // a cr that turned out not to end the line
      emit_beat(held[0], KIND_BYTE);
      held_n = 2'd0;
    end
    if (b == CH_PCT || b == CH_CR) begin
      held[0] = b;
      held_n  = 2'd1;
    end else begin
      emit_beat(b, KIND_BYTE);
    end
  endfunction

  function automatic void decode_text_byte(logic [7:0] b, logic eot);
    step_beats.delete();
    if (b == CH_LF) begin
      if (line_phase == PH_PATH) flush_and_close();
      restart_line();
    end else begin
      case (line_phase)
        PH_SCHEME: begin
          if (match_idx < SCHEME_LEN && b == SCHEME_TXT[match_idx]) begin
            match_idx++;
            if (match_idx == SCHEME_LEN) begin
              line_phase = PH_AUTH;
              match_idx  = 4'd0;
            end
          end else begin
            line_phase = PH_SKIP;
          end
        end
        PH_AUTH: begin
          if (b == CH_SLASH) begin
            // empty authority or exactly localhost
            if (match_idx == 4'd0 || match_idx == HOST_LEN) begin
              line_phase = PH_PATH;
              held_n     = 2'd0;
              emit_beat(b, KIND_BYTE);
            end else begin
              line_phase = PH_SKIP;
            end
          end else if (match_idx < HOST_LEN && b == HOST_TXT[match_idx]) begin
            match_idx++;
          end else begin
            line_phase = PH_SKIP;
          end
        end
        PH_PATH: take_path_byte(b);
        default: ;
      endcase
      // end of text closes the last line as a line feed would
      if (eot) begin
        if (line_phase == PH_PATH) flush_and_close();
        restart_line();
      end
    end
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].run_last = 1'b1;
    foreach (step_beats[i]) path_beats_due.insert(path_beats_due.size(), step_beats[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus construction
  // ---------------------------------------------------------------------------
  function automatic void push_byte(logic [7:0] b, logic eot);
    text_beat_t t;
    t = '{b, eot};
    text_bytes.insert(text_bytes.size(), t);
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endfunction

  function automatic logic [7:0] hex_char(int n, bit upper);
    if (n < 10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n - 10);
  endfunction

  function automatic logic [7:0] non_hex_char();
    return NON_HEX_TXT[$urandom_range(NON_HEX_TXT.len() - 1)];
  endfunction

  function automatic logic [7:0] any_but_lf();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == CH_LF) b = 8'hFF;
    return b;
  endfunction

  // one piece of a path, biased towards escapes and held bytes
  function automatic void add_path_token();
    case ($urandom_range(9))
      0, 1: push_byte(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
      2: begin
        push_byte(CH_PCT, 1'b0);
        push_byte(hex_char($urandom_range(15), $urandom_range(1)), 1'b0);
        push_byte(hex_char($urandom_range(15), $urandom_range(1)), 1'b0);
      end
      3: begin
        push_byte(CH_PCT, 1'b0);
        push_byte(non_hex_char(), 1'b0);
      end
      4: begin
        push_byte(CH_PCT, 1'b0);
        push_byte(hex_char($urandom_range(15), $urandom_range(1)), 1'b0);
        push_byte(non_hex_char(), 1'b0);
      end
      5: push_byte(CH_CR, 1'b0);
      6: push_byte(any_but_lf(), 1'b0);
      7: push_str("%00");
      8: push_byte(CH_SLASH, 1'b0);
      default: push_byte(CH_PCT, 1'b0);
    endcase
  endfunction

  // lf, cr lf, or end of text on the last byte
  function automatic void close_line();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: push_byte(CH_LF, 1'b0);
      5, 6, 7: begin
        push_byte(CH_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
      end
      8: begin
        if (text_bytes.size() > 0) text_bytes[text_bytes.size() - 1].eot = 1'b1;
        else push_byte(CH_LF, 1'b0);
      end
      default: push_byte(CH_CR, 1'b1);
    endcase
  endfunction

  function automatic void add_path_line();
    push_str(SCHEME_TXT);
    if ($urandom_range(1)) push_str(HOST_TXT);
    push_byte(CH_SLASH, 1'b0);
    repeat ($urandom_range(10)) add_path_token();
    close_line();
  endfunction

  function automatic void add_noise_line();
    int k;
    case ($urandom_range(5))
      0: begin
        // scheme broken part way through
        k = $urandom_range(6);
        for (int i = 0; i < k; i++) push_byte(SCHEME_TXT[i], 1'b0);
        push_byte(any_but_lf(), 1'b0);
        repeat ($urandom_range(4)) add_path_token();
      end
      1: begin
        // authority that is neither empty nor localhost
        push_str(SCHEME_TXT);
        k = $urandom_range(1, 8);
        for (int i = 0; i < k; i++) push_byte(HOST_TXT[i], 1'b0);
        if ($urandom_range(1)) push_byte(non_hex_char(), 1'b0);
        push_byte(CH_SLASH, 1'b0);
        repeat ($urandom_range(3)) add_path_token();
      end
      2: begin
        push_str("file://localhostx/");
        repeat ($urandom_range(3)) add_path_token();
      end
      3: begin
        push_byte(8'h23, 1'b0);
        repeat ($urandom_range(6)) push_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
      end
      4: repeat ($urandom_range(8)) push_byte(8'($urandom_range(255)), 1'b0);
      default: begin
        // line ends before the slash
        push_str(SCHEME_TXT);
        if ($urandom_range(1)) push_str(HOST_TXT);
      end
    endcase
    close_line();
  endfunction

  // idle percentage of each side, by how far the text has got
  function automatic int idle_pct(bit rx_side);
    if (n_in_beats < n_total / 3) return rx_side ? 70 : 36;
    if (n_in_beats < 2 * n_total / 3) return rx_side ? 36 : 70;
    return 0;
  endfunction

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= MAX_PRINTED) $display("mismatch at result beat %0d: %s", n_out_beats, what);
  endtask

  // ---------------------------------------------------------------------------
  // driver: feeds text bytes, runs the model on every accepted beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_text_byte(in_ch.in_byte, in_ch.end_of_text);
        n_in_beats <= n_in_beats + 1;
      end
      // only move on once the current beat is gone
      if (!in_ch.valid || in_ch.ready) begin
        if (text_bytes.size() > 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          in_ch.valid       <= 1'b1;
          in_ch.in_byte     <= text_bytes[0].b;
          in_ch.end_of_text <= text_bytes[0].eot;
          void'(text_bytes.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure, compares beats, watchdog on no progress
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    path_beat_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      idle_cycles  <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= idle_pct(1'b1));
      if (out_ch.valid && out_ch.ready) begin
        if (path_beats_due.size() == 0) begin
          report_mismatch($sformatf("unexpected beat byte %02h kind %0d",
                                    out_ch.out_byte, out_ch.kind));
        end else begin
          e = path_beats_due.pop_front();
          if (out_ch.out_byte !== e.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_ch.out_byte, e.data));
          if (out_ch.kind !== e.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_ch.kind, e.kind));
          if (out_ch.run_last !== e.run_last)
            report_mismatch($sformatf("run_last %0b, want %0b", out_ch.run_last, e.run_last));
        end
        n_out_beats <= n_out_beats + 1;
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("uri_list_path_decoder_core_tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int n_directed;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.in_byte     = 8'h00;
    in_ch.end_of_text = 1'b0;
    out_ch.ready      = 1'b0;
    n_in_beats        = 0;
    n_out_beats       = 0;
    n_errors          = 0;
    idle_cycles       = 0;
    held              = '{default: 8'h00};
    restart_line();

    // percent with one digit, then a cr before the line feed
    push_str("file:///%4");
    push_byte(CH_CR, 1'b0);
    push_byte(CH_LF, 1'b0);
    // localhost, mixed-case escape, decoded nul with bytes after it
    push_str("file://localhost/%fF%00z");
    push_byte(CH_LF, 1'b0);
    // skipped line and bad authority
    push_str("#x");
    push_byte(CH_LF, 1'b0);
    push_str("file://lo/x");
    push_byte(CH_LF, 1'b0);
    // cr inside the path, stray percent flushed at end of text
    push_str("file:///");
    push_byte(CH_CR, 1'b0);
    push_str("a%4");
    push_byte(CH_PCT, 1'b1);
    // raw extremes, cr dropped at end of text
    push_str("file:///");
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(CH_CR, 1'b1);
    n_directed = text_bytes.size();

    // mostly well-formed file urls, the rest noise and broken lines
    while (text_bytes.size() < n_directed + RANDOM_BYTES) begin
      if ($urandom_range(99) < 75) add_path_line();
      else add_noise_line();
    end
    n_total = text_bytes.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // checked away from the active edge so the queues are settled
    @(negedge clk);
    while (text_bytes.size() > 0 || in_ch.valid || path_beats_due.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (n_errors == 0) begin
      $display("uri_list_path_decoder_core_tb: clean");
    end else begin
      $display("uri_list_path_decoder_core_tb: errors");
    end
    $finish;
  end

endmodule
